>>> hw/rtl/itar_pkg.sv
// Shared types, constants and helpers for the radix text converter.
`timescale 1ns / 1ps
package itar_pkg;

	// Value and radix widths.
	localparam int VALUE_W   = 32;
	localparam int RADIX_W   = 6;
	localparam int CHAR_W    = 8;
	localparam int REM_W     = RADIX_W + 1;
	localparam int CHUNK_W   = 8;
	localparam int CHUNKS    = VALUE_W / CHUNK_W;
	localparam int CHUNK_CW  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int NDIG_W    = $clog2(VALUE_W + 1);
	localparam int DIG_IDX_W = $clog2(VALUE_W);
	localparam int PC_W      = 3;

	// Radix limits and reset value.
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

	// Character codes.
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h41;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [RADIX_W-1:0] DEC_DIGITS = RADIX_W'(10);

	// Microcode jump conditions.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_START,
		C_DIV_RUN,
		C_QUOT_NZ,
		C_POS,
		C_MORE
	} cond_t;

	// Datapath controls of one microcode word.
	typedef struct packed {
		logic load;
		logic div;
		logic push;
		logic emit_sign;
		logic emit_digit;
	} ctrl_t;

	// Full microcode word.
	typedef struct packed {
		ctrl_t            ctrl;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} uword_t;

	// Datapath status that the sequencer branches on.
	typedef struct packed {
		logic div_last;
		logic quot_nz;
		logic neg;
		logic more;
	} stat_t;

	// Map one digit value to its ASCII character.
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d < DEC_DIGITS) begin
			res = CH_ZERO + CHAR_W'(d);
		end else begin
			res = CH_ALPHA + CHAR_W'(d - DEC_DIGITS);
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/int_to_ascii_radix_top.sv
// Top level of the signed integer to ASCII converter with a programmable radix.
`timescale 1ns / 1ps
// Usage:
//   A 32-bit signed number is taken at a rising edge with start high and busy low.
//   The text comes out most significant character first, one per cycle on
//   ascii_char with char_strobe high for one cycle; last_char marks the final
//   character. A negative value is preceded by '-'; zero gives a single '0'.
//   The user must write the radix register (2..36, reset 10) with radix_we and
//   radix_wdata only while busy is low; the block does not enforce this. Values
//   outside 2..36 are ignored.
// Sequence:
//   For each digit the division unit passes over the value in 8-bit chunks,
//   retiring eight quotient bits per cycle, and the remainder is then stored
//   in the digit buffer; digits repeat while the quotient is nonzero. The
//   characters then leave back to back after the sign test step, the last in
//   the final busy cycle. The block takes the next number once busy is low.
// Reset and flow:
//   Reset returns the sequencer to idle and the radix to 10. The receiver
//   cannot stall; every strobed character is a transfer.
module int_to_ascii_radix_top
	import itar_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [VALUE_W-1:0] number,
	input  logic                      radix_we,
	input  logic [RADIX_W-1:0]        radix_wdata,
	output logic [CHAR_W-1:0]         ascii_char,
	output logic                      last_char,
	output logic                      char_strobe
);

	ctrl_t ctrl;
	stat_t stat;

	// Microcode sequencer.
	itar_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// Datapath.
	itar_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.ctrl        (ctrl),
		.number      (number),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.stat        (stat),
		.ascii_char  (ascii_char),
		.last_char   (last_char),
		.char_strobe (char_strobe)
	);

	// A character is only produced while a conversion is running.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		char_strobe |-> $past(busy))
		else $error("character strobe outside a conversion");

	// A conversion ends only right after its final character.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(char_strobe && last_char))
		else $error("conversion ended without a final character");

	// Characters of one number leave in consecutive cycles.
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(char_strobe && !last_char) |=> char_strobe)
		else $error("gap in the character stream");

endmodule

>>> hw/rtl/itar_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps
module itar_seq
	import itar_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output ctrl_t ctrl,
	output logic  busy
);

	// Step addresses of the program.
	localparam logic [PC_W-1:0] PC_IDLE = PC_W'(0);
	localparam logic [PC_W-1:0] PC_DIV  = PC_W'(1);
	localparam logic [PC_W-1:0] PC_PUSH = PC_W'(2);
	localparam logic [PC_W-1:0] PC_SGNT = PC_W'(3);
	localparam logic [PC_W-1:0] PC_SIGN = PC_W'(4);
	localparam logic [PC_W-1:0] PC_EMIT = PC_W'(5);
	localparam logic [PC_W-1:0] PC_RET  = PC_W'(6);

	localparam ctrl_t NO_OP = '{load: 1'b0, div: 1'b0, push: 1'b0,
		emit_sign: 1'b0, emit_digit: 1'b0};

	// Control store: a jump is taken when the condition holds, else the next step follows.
	function automatic uword_t ucode(input logic [PC_W-1:0] a);
		uword_t w;
		w = '{ctrl: NO_OP, cond: C_ALWAYS, target: PC_IDLE};
		unique case (a)
			PC_IDLE: begin
				w.ctrl.load = 1'b1;
				w.cond      = C_NO_START;
				w.target    = PC_IDLE;
			end
			PC_DIV: begin
				w.ctrl.div = 1'b1;
				w.cond     = C_DIV_RUN;
				w.target   = PC_DIV;
			end
			PC_PUSH: begin
				w.ctrl.push = 1'b1;
				w.cond      = C_QUOT_NZ;
				w.target    = PC_DIV;
			end
			PC_SGNT: begin
				w.cond   = C_POS;
				w.target = PC_EMIT;
			end
			PC_SIGN: begin
				w.ctrl.emit_sign = 1'b1;
				w.cond           = C_NEVER;
			end
			PC_EMIT: begin
				w.ctrl.emit_digit = 1'b1;
				w.cond            = C_MORE;
				w.target          = PC_EMIT;
			end
			PC_RET: begin
				w.cond   = C_ALWAYS;
				w.target = PC_IDLE;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

	logic [PC_W-1:0] pc_q;
	uword_t          word;
	logic            take;

	assign word = ucode(pc_q);
	assign ctrl = word.ctrl;
	assign busy = (pc_q != PC_IDLE);

	// Branch condition select.
	always_comb begin
		unique case (word.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_START: take = !start;
			C_DIV_RUN:  take = !stat.div_last;
			C_QUOT_NZ:  take = stat.quot_nz;
			C_POS:      take = !stat.neg;
			C_MORE:     take = stat.more;
			default:    take = 1'b1;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= take ? word.target : pc_q + PC_W'(1);
		end
	end

endmodule

>>> hw/rtl/itar_dpath.sv
// Datapath: magnitude, chunked radix division, digit buffer and character output.
`timescale 1ns / 1ps
module itar_dpath
	import itar_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ctrl_t               ctrl,
	input  logic signed [VALUE_W-1:0] number,
	input  logic                radix_we,
	input  logic [RADIX_W-1:0]  radix_wdata,
	output stat_t               stat,
	output logic [CHAR_W-1:0]   ascii_char,
	output logic                last_char,
	output logic                char_strobe
);

	logic [RADIX_W-1:0]   radix_q;
	logic                 neg_q;
	logic [VALUE_W-1:0]   mag_q;
	logic [RADIX_W-1:0]   rem_q;
	logic [CHUNK_CW-1:0]  chunk_q;
	logic [NDIG_W-1:0]    nd_q;
	logic [RADIX_W-1:0]   digits_q [VALUE_W];
	logic [VALUE_W-1:0]   mag_nxt;
	logic [RADIX_W-1:0]   rem_nxt;
	logic [NDIG_W-1:0]    nd_dec;

	// Radix register: writes outside the legal range are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_we && radix_wdata >= RADIX_MIN && radix_wdata <= RADIX_MAX) begin
			radix_q <= radix_wdata;
		end
	end

	// One chunk of restoring division: quotient bits shift into the magnitude register.
	always_comb begin
		logic [REM_W-1:0]   t;
		logic [VALUE_W-1:0] m;
		logic [RADIX_W-1:0] r;
		m = mag_q;
		r = rem_q;
		for (int k = 0; k < CHUNK_W; k++) begin
			t = {r, m[VALUE_W-1]};
			m = {m[VALUE_W-2:0], 1'b0};
			if (t >= REM_W'(radix_q)) begin
				t    = t - REM_W'(radix_q);
				m[0] = 1'b1;
			end
			r = t[RADIX_W-1:0];
		end
		mag_nxt = m;
		rem_nxt = r;
	end

	assign nd_dec = nd_q - NDIG_W'(1);

	// Status for the sequencer.
	assign stat.div_last = (chunk_q == CHUNK_CW'(CHUNKS - 1));
	assign stat.quot_nz  = (mag_q != '0);
	assign stat.neg      = neg_q;
	assign stat.more     = (nd_q != NDIG_W'(1));

	// Control registers of the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q     <= '0;
			nd_q        <= '0;
			char_strobe <= 1'b0;
		end else begin
			char_strobe <= ctrl.emit_sign || ctrl.emit_digit;
			if (ctrl.load && start) begin
				chunk_q <= '0;
				nd_q    <= '0;
			end
			if (ctrl.div) begin
				chunk_q <= stat.div_last ? '0 : chunk_q + CHUNK_CW'(1);
			end
			if (ctrl.push) begin
				nd_q <= nd_q + NDIG_W'(1);
			end
			if (ctrl.emit_digit) begin
				nd_q <= nd_dec;
			end
		end
	end

	// Payload registers: value, remainder, digit buffer and output character.
	always_ff @(posedge clk) begin
		if (ctrl.load && start) begin
			neg_q <= number[VALUE_W-1];
			mag_q <= number[VALUE_W-1] ? (~number + VALUE_W'(1)) : number;
			rem_q <= '0;
		end
		if (ctrl.div) begin
			mag_q <= mag_nxt;
			rem_q <= rem_nxt;
		end
		if (ctrl.push) begin
			digits_q[nd_q[DIG_IDX_W-1:0]] <= rem_q;
			rem_q <= '0;
		end
		if (ctrl.emit_sign) begin
			ascii_char <= CH_MINUS;
			last_char  <= 1'b0;
		end
		if (ctrl.emit_digit) begin
			ascii_char <= digit_to_ascii(digits_q[nd_dec[DIG_IDX_W-1:0]]);
			last_char  <= (nd_q == NDIG_W'(1));
		end
	end

endmodule
